FILE: hdl/steering_profile_interpolator_unit_assert.svh
// Assertion macros for the steering profile interpolator.
// Each expects clk and arst_n in scope.
`ifndef STEERING_PROFILE_INTERPOLATOR_UNIT_ASSERT_SVH
`define STEERING_PROFILE_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define SPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("steering profile interpolator: check failed");

// Next-cycle implication
`define SPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("steering profile interpolator: check failed");

`endif

FILE: hdl/spi_pkg.sv
package spi_pkg;

	// default table depth
	localparam int unsigned MAX_POINTS_DEF = 64;

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0] ang_t;  // 0 pitch, 1 yaw, 2 roll

	typedef struct packed {
		word_t tm;
		ang_t  ang;
	} point_t;

	// register indexes on the APB port
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_START_TIME = 2'd0;
	localparam reg_idx_t REG_TIME_TOL   = 2'd1;
	localparam reg_idx_t REG_POINT_CNT  = 2'd2;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// result regions
	localparam logic [1:0] REGION_BEFORE = 2'd0;
	localparam logic [1:0] REGION_INTERP = 2'd1;
	localparam logic [1:0] REGION_AFTER  = 2'd2;
	localparam logic [1:0] REGION_HOLD   = 2'd3;

	// fraction of one, and last step of the 17-bit divider
	localparam logic [16:0] ALPHA_ONE = 17'h10000;
	localparam logic [4:0]  DIV_LAST  = 5'd16;
	localparam logic [1:0]  ANG_LAST  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_DIFF,
		S_DIV,
		S_MUL,
		S_ADD
	} state_t;

endpackage

FILE: hdl/steering_profile_interpolator_unit.sv
// Steering profile interpolator.
// Items come in on start/busy: an item is taken at a clock edge with start high
// and busy low. cmd selects a load (write one table point at point_index, no
// result) or a query at query_time (one result, marked by done for
// exactly one cycle on pitch_out/yaw_out/roll_out/region).
// Registers start_time, time_tolerance and point_count sit on the APB port at
// byte addresses 0, 4 and 8; write them only while busy is low.
// A query ends clamped to the first point, clamped to the last point, held on
//   a short interval, or interpolated (without the divider when the fraction
//   saturates); the last two follow a scan for the bracketing interval.
// The table has one write and one registered read port and is scanned one
// entry per cycle; the fraction comes from a restoring divider at one bit per
// cycle, and the three angles share one 18x33 multiplier, each angle taking
// a multiply state and an add state.
// Reset restores the register defaults and idles the sequencer; table content
// is undefined until loaded. The receiver cannot stall: done is not held.
module steering_profile_interpolator_unit import spi_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [5:0]  point_index,
	input  word_t       point_time,
	input  word_t       point_pitch,
	input  word_t       point_yaw,
	input  word_t       point_roll,
	input  word_t       query_time,
	output logic        done,
	output word_t       pitch_out,
	output word_t       yaw_out,
	output word_t       roll_out,
	output logic [1:0]  region
);

	localparam int unsigned IDX_W = $clog2(MAX_POINTS);

	// configuration
	word_t        start_q;
	logic [30:0]  tol_q;
	logic [6:0]   cnt_cfg_q;

	// sequencer
	state_t       state_q, state_d;
	logic         finish;
	logic         done_q;
	logic [IDX_W-1:0] rd_addr;

	// table
	point_t       mem [MAX_POINTS];
	point_t       rd_q;
	logic         mem_we;

	// datapath registers
	logic signed [32:0] elapsed_q;
	logic [IDX_W-1:0]   last_q;
	logic [IDX_W-1:0]   i_q;
	point_t       prv_q, nxt_q;
	logic [32:0]  rem_q, dvs_q;
	logic [16:0]  nbits_q, quo_q, alpha_q;
	logic [4:0]   cnt_q;
	logic [1:0]   k_q;
	logic signed [50:0] prod_q;
	ang_t         out_q;
	logic [1:0]   region_q;

	// combinational
	logic         acc_go, q_go, ld_go, cfg_wr;
	logic [31:0]  cnt_ext, n_ext;
	logic [IDX_W-1:0] last_d;
	logic signed [32:0] elapsed_d, q33, s33, rd_t33, prv_t33, nxt_t33, dt;
	logic [32:0]  adt;
	logic signed [33:0] diff, e34, p34;
	logic [32:0]  dabs;
	logic         hit_first, hit_last, scan_more, hold_iv, neg, ovf, skip_div;
	logic [33:0]  trial;
	logic         ge;
	logic [16:0]  q17, alpha_fin;
	logic signed [17:0] alpha_s;
	logic signed [32:0] a0_33, a1_33, adiff;
	logic signed [50:0] prod_d;
	word_t        sum;

	// handshake decode
	assign acc_go = start && !busy;
	assign q_go   = acc_go && (cmd == CMD_QUERY);
	assign ld_go  = acc_go && (cmd == CMD_LOAD);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign mem_we = ld_go && (32'(point_index) < 32'(MAX_POINTS));

	// effective point count, clamped to 1..MAX_POINTS
	assign cnt_ext = {25'd0, cnt_cfg_q};
	assign n_ext   = (cnt_ext == 32'd0) ? 32'd1 :
		((cnt_ext > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : cnt_ext);
	assign last_d  = IDX_W'(n_ext - 32'd1);

	// elapsed time, exact in 33 bits
	assign q33       = {query_time[31], query_time};
	assign s33       = {start_q[31], start_q};
	assign elapsed_d = q33 - s33;

	// compares against the entry just read
	assign rd_t33    = {rd_q.tm[31], rd_q.tm};
	assign hit_first = elapsed_q <= rd_t33;
	assign hit_last  = elapsed_q >= rd_t33;
	assign scan_more = ((IDX_W+1)'(i_q) + (IDX_W+1)'(1) < (IDX_W+1)'(last_q))
		&& (rd_t33 < elapsed_q);

	// interval length and tolerance test
	assign prv_t33 = {prv_q.tm[31], prv_q.tm};
	assign nxt_t33 = {nxt_q.tm[31], nxt_q.tm};
	assign dt      = nxt_t33 - prv_t33;
	assign adt     = dt[32] ? 33'(-dt) : 33'(dt);
	assign hold_iv = (adt < {2'b00, tol_q}) || (dt == 33'sd0);

	// fraction set-up: offset magnitude, sign and saturation
	assign e34      = {elapsed_q[32], elapsed_q};
	assign p34      = {prv_q.tm[31], prv_q.tm[31], prv_q.tm};
	assign diff     = e34 - p34;
	assign dabs     = diff[33] ? 33'(-diff) : 33'(diff);
	assign neg      = (diff[33] != dt[32]) && (diff != 34'sd0);
	assign ovf      = (dabs >> 1) >= adt;
	assign skip_div = neg || ovf;

	// restoring divider step
	assign trial     = {rem_q, nbits_q[16]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign q17       = {quo_q[15:0], ge};
	assign alpha_fin = (q17 > ALPHA_ONE) ? ALPHA_ONE : q17;

	// shared multiplier and accumulate
	assign alpha_s = {1'b0, alpha_q};
	assign a0_33   = {prv_q.ang[k_q][31], prv_q.ang[k_q]};
	assign a1_33   = {nxt_q.ang[k_q][31], nxt_q.ang[k_q]};
	assign adiff   = a1_33 - a0_33;
	assign prod_d  = alpha_s * adiff;
	assign sum     = prv_q.ang[k_q] + word_t'(prod_q[47:16]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (q_go) state_d = S_FIRST;
			S_FIRST: state_d = hit_first ? S_IDLE : S_LAST;
			S_LAST:  state_d = hit_last ? S_IDLE : S_SCAN;
			S_SCAN:  if (!scan_more) state_d = S_DIFF;
			S_DIFF: begin
				if (hold_iv) state_d = S_IDLE;
				else if (skip_div) state_d = S_MUL;
				else state_d = S_DIV;
			end
			S_DIV:   if (cnt_q == DIV_LAST) state_d = S_MUL;
			S_MUL:   state_d = S_ADD;
			S_ADD:   state_d = (k_q == ANG_LAST) ? S_IDLE : S_MUL;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		finish  = 1'b0;
		rd_addr = '0;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:  rd_addr = '0;
			S_FIRST: begin
				rd_addr = last_q;
				finish  = hit_first;
			end
			S_LAST: begin
				rd_addr = IDX_W'(1);
				finish  = hit_last;
			end
			S_SCAN:  rd_addr = i_q + IDX_W'(2);
			S_DIFF:  finish = hold_iv;
			S_ADD:   finish = (k_q == ANG_LAST);
			default: finish = 1'b0;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			start_q   <= '0;
			tol_q     <= 31'd1;
			cnt_cfg_q <= 7'd1;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_START_TIME: start_q   <= pwdata;
					REG_TIME_TOL:   tol_q     <= pwdata[30:0];
					REG_POINT_CNT:  cnt_cfg_q <= pwdata[6:0];
					default: ;
				endcase
			end
		end
	end

	// profile table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IDX_W'(point_index)] <= '{tm: point_time,
				ang: {point_roll, point_yaw, point_pitch}};
		end
		rd_q <= mem[rd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_go) begin
			elapsed_q <= elapsed_d;
			last_q    <= last_d;
		end
		case (state_q)
			S_FIRST: begin
				if (hit_first) begin
					out_q    <= rd_q.ang;
					region_q <= REGION_BEFORE;
				end else begin
					prv_q <= rd_q;
				end
			end
			S_LAST: begin
				if (hit_last) begin
					out_q    <= rd_q.ang;
					region_q <= REGION_AFTER;
				end else begin
					i_q <= '0;
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					prv_q <= rd_q;
					i_q   <= i_q + IDX_W'(1);
				end else begin
					nxt_q <= rd_q;
				end
			end
			S_DIFF: begin
				if (hold_iv) begin
					out_q    <= prv_q.ang;
					region_q <= REGION_HOLD;
				end
				rem_q   <= dabs >> 1;
				dvs_q   <= adt;
				nbits_q <= {dabs[0], 16'd0};
				quo_q   <= '0;
				cnt_q   <= '0;
				k_q     <= '0;
				alpha_q <= neg ? 17'd0 : ALPHA_ONE;
			end
			S_DIV: begin
				rem_q   <= ge ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
				quo_q   <= q17;
				nbits_q <= {nbits_q[15:0], 1'b0};
				cnt_q   <= cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) alpha_q <= alpha_fin;
			end
			S_MUL:   prod_q <= prod_d;
			S_ADD: begin
				out_q[k_q] <= sum;
				if (k_q == ANG_LAST) region_q <= REGION_INTERP;
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	// ports
	assign pready    = 1'b1;
	assign done      = done_q;
	assign pitch_out = out_q[0];
	assign yaw_out   = out_q[1];
	assign roll_out  = out_q[2];
	assign region    = region_q;

	// register read-back
	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_START_TIME: prdata = start_q;
			REG_TIME_TOL:   prdata = {1'b0, tol_q};
			REG_POINT_CNT:  prdata = {25'd0, cnt_cfg_q};
			default:        prdata = '0;
		endcase
	end

	// checks
	`include "steering_profile_interpolator_unit_assert.svh"

	`SPI_ASSERT_NEXT(a_done_single, done, !done)
	`SPI_ASSERT_NEXT(a_load_no_busy, ld_go, !busy)
	`SPI_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, i_q < last_q)
	`SPI_ASSERT_IMP(a_interp_path, done && (region == REGION_INTERP), $past(state_q) == S_ADD)

endmodule

FILE: tb/sv/steering_profile_checker.sv
module steering_profile_checker import spi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [5:0]  point_index,
	input  word_t       point_time,
	input  word_t       point_pitch,
	input  word_t       point_yaw,
	input  word_t       point_roll,
	input  word_t       query_time,
	input  logic        done,
	input  word_t       pitch_out,
	input  word_t       yaw_out,
	input  logic [1:0]  region,
	input  word_t       roll_out,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		word_t      pitch;
		word_t      yaw;
		word_t      roll;
		logic [1:0] rgn;
	} attitude_t;

	// mirrored registers and profile table
	word_t       cfg_start;
	logic [30:0] cfg_tol;
	logic [6:0]  cfg_count;
	word_t       prof_time [MAX_POINTS_DEF];
	word_t       prof_ang  [MAX_POINTS_DEF][3];

	attitude_t   expected_att [$];
	int          mismatches;

	// angles of one stored point, unchanged
	function automatic attitude_t point_attitude(int idx, logic [1:0] rgn);
		attitude_t att;
		att.pitch = prof_ang[idx][0];
		att.yaw   = prof_ang[idx][1];
		att.roll  = prof_ang[idx][2];
		att.rgn   = rgn;
		return att;
	endfunction

	// attitude at an absolute time: clamp, bracket, hold or interpolate
	function automatic attitude_t predict_attitude(word_t qtime);
		int        n;
		int        last;
		int        seg;
		longint    elapsed;
		longint    t0;
		longint    t1;
		longint    dt;
		longint    adt;
		longint    tol;
		longint    alpha;
		longint    a0;
		longint    a1;
		longint    r;
		word_t     ang [3];
		attitude_t att;
		n = int'(cfg_count);
		if (n < 1)
			n = 1;
		if (n > int'(MAX_POINTS_DEF))
			n = int'(MAX_POINTS_DEF);
		last = n - 1;
		tol = longint'(cfg_tol);
		// 33-bit exact difference
		elapsed = longint'(qtime) - longint'(cfg_start);
		if (elapsed <= longint'(prof_time[0]))
			return point_attitude(0, REGION_BEFORE);
		if (elapsed >= longint'(prof_time[last]))
			return point_attitude(last, REGION_AFTER);
		// first following point not below elapsed, never past second-to-last
		seg = 0;
		while (seg < n - 2 && longint'(prof_time[seg + 1]) < elapsed)
			seg++;
		t0 = longint'(prof_time[seg]);
		t1 = longint'(prof_time[seg + 1]);
		dt = t1 - t0;
		adt = (dt < 0) ? -dt : dt;
		if (adt < tol || dt == 0)
			return point_attitude(seg, REGION_HOLD);
		// 16-bit fraction, truncated toward zero, saturated to zero and one
		alpha = ((elapsed - t0) * 65536) / dt;
		if (alpha < 0)
			alpha = 0;
		if (alpha > 65536)
			alpha = 65536;
		for (int k = 0; k < 3; k++) begin
			a0 = longint'(prof_ang[seg][k]);
			a1 = longint'(prof_ang[seg + 1][k]);
			r = a0 + ((alpha * (a1 - a0)) >>> 16);
			ang[k] = word_t'(r);
		end
		att.pitch = ang[0];
		att.yaw   = ang[1];
		att.roll  = ang[2];
		att.rgn   = REGION_INTERP;
		return att;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		attitude_t want;
		if (!arst_n) begin
			cfg_start = '0;
			cfg_tol   = 31'd1;
			cfg_count = 7'd1;
			expected_att.delete();
			mismatches = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_START_TIME: cfg_start = pwdata;
					REG_TIME_TOL:   cfg_tol   = pwdata[30:0];
					REG_POINT_CNT:  cfg_count = pwdata[6:0];
					default: ;
				endcase
			end
			// results against the oldest expectation
			if (done) begin
				if (expected_att.size() == 0) begin
					mismatches++;
					$error("result with no query waiting");
				end else begin
					want = expected_att.pop_front();
					if (pitch_out !== want.pitch) begin
						mismatches++;
						$error("pitch_out: expected %0d, got %0d", want.pitch, pitch_out);
					end
					if (yaw_out !== want.yaw) begin
						mismatches++;
						$error("yaw_out: expected %0d, got %0d", want.yaw, yaw_out);
					end
					if (roll_out !== want.roll) begin
						mismatches++;
						$error("roll_out: expected %0d, got %0d", want.roll, roll_out);
					end
					if (region !== want.rgn) begin
						mismatches++;
						$error("region: expected %0d, got %0d", want.rgn, region);
					end
				end
			end
			// accepted items
			if (start && !busy) begin
				if (cmd == CMD_LOAD) begin
					prof_time[point_index]    = point_time;
					prof_ang[point_index][0] = point_pitch;
					prof_ang[point_index][1] = point_yaw;
					prof_ang[point_index][2] = point_roll;
				end else begin
					expected_att.push_back(predict_attitude(query_time));
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= expected_att.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top import spi_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT     = 1000000;
	localparam int          PHASES          = 16;
	localparam int          ITEMS_PER_PHASE = 75;
	localparam int          SETTLE_CYCLES   = 100;
	localparam longint      T_MIN           = -longint'(32'h8000_0000);
	localparam longint      T_MAX           = longint'(32'h7fff_ffff);

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [5:0]  point_index;
	word_t       point_time;
	word_t       point_pitch;
	word_t       point_yaw;
	word_t       point_roll;
	word_t       query_time;
	logic        done;
	word_t       pitch_out;
	word_t       yaw_out;
	word_t       roll_out;
	logic [1:0]  region;
	int          fail_count;
	int          outstanding;

	// stimulus-side view of the profile and settings
	int          idle_pct;
	int          eff_n;
	word_t       cur_start;
	logic [30:0] cur_tol;
	word_t       plan_time [MAX_POINTS_DEF];

	steering_profile_interpolator_unit uut (.*);

	steering_profile_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return word_t'($urandom_range(0, 64)) - word_t'(32);
			default: return $urandom;
		endcase
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// wait until no query is pending and the sequencer has gone idle
	task automatic drain();
		start = 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(word_t s, logic [30:0] tol, logic [6:0] cnt);
		drain();
		apb_write(REG_START_TIME, s);
		apb_write(REG_TIME_TOL, {1'b0, tol});
		apb_write(REG_POINT_CNT, {25'd0, cnt});
		cur_start = s;
		cur_tol   = tol;
		if (cnt == 0)
			eff_n = 1;
		else if (cnt > MAX_POINTS_DEF)
			eff_n = int'(MAX_POINTS_DEF);
		else
			eff_n = int'(cnt);
	endtask

	// one item, after a random gap; returns at the falling edge after acceptance
	task automatic issue(logic c, logic [5:0] idx, word_t t, word_t p, word_t y, word_t r,
			word_t q);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start       = 1'b1;
		cmd         = c;
		point_index = idx;
		point_time  = t;
		point_pitch = p;
		point_yaw   = y;
		point_roll  = r;
		query_time  = q;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic load_point(logic [5:0] idx, word_t t, word_t p, word_t y, word_t r);
		issue(CMD_LOAD, idx, t, p, y, r, rand_word());
		plan_time[idx] = t;
	endtask

	task automatic send_query(word_t q);
		issue(CMD_QUERY, 6'($urandom), rand_word(), rand_word(), rand_word(), rand_word(), q);
	endtask

	initial begin : stimulus
		longint      cur;
		longint      room;
		longint      step;
		longint      lo;
		longint      hi;
		longint      e;
		int          j;
		int          small_tol;
		word_t       s;
		logic [30:0] tol;
		logic [6:0]  cnt;
		bit          ordered;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		cmd         = CMD_LOAD;
		point_index = '0;
		point_time  = '0;
		point_pitch = '0;
		point_yaw   = '0;
		point_roll  = '0;
		query_time  = '0;
		idle_pct    = 0;
		eff_n       = 1;
		cur_start   = '0;
		cur_tol     = 31'd1;
		// entries not yet planned reload with time zero
		foreach (plan_time[i])
			plan_time[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// single point at reset settings: every query clamps to it
		load_point(0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_query(-1);
		send_query(0);
		send_query(1);
		send_query(32'h8000_0000);
		send_query(32'h7fff_ffff);

		// full-range intervals, extreme angles, zero tolerance
		configure(32'h8000_0000, 31'd0, 7'd3);
		load_point(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		load_point(1, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		load_point(2, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff);
		send_query(32'h8000_0000);	// exactly on the middle point
		send_query(32'h8000_0001);
		send_query(32'hc000_0000);
		send_query(32'h7fff_ffff);

		// widest tolerance: interval held at the earlier point
		configure(0, 31'h7fff_ffff, 7'd2);
		load_point(0, 0, 100, 200, 300);
		load_point(1, 100, -100, -200, -300);
		send_query(50);
		send_query(100);

		// coincident times with zero tolerance
		configure(0, 31'd0, 7'd3);
		load_point(0, 10, 1, 2, 3);
		load_point(1, 10, 4, 5, 6);
		load_point(2, 10, 7, 8, 9);
		send_query(10);
		send_query(11);

		// random phases over register settings and idle patterns
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: s = 0;
				1: s = 32'h8000_0000;
				2: s = 32'h7fff_ffff;
				default: s = $urandom;
			endcase
			case (ph % 5)
				0: tol = 31'd1;
				1: tol = 31'd0;
				2: tol = 31'($urandom_range(0, 64));
				3: tol = 31'($urandom_range(0, 1 << 20));
				default: tol = (ph == 4) ? 31'h7fff_ffff : 31'($urandom);
			endcase
			case (ph % 7)
				0: cnt = 7'd2;
				1: cnt = 7'd64;
				2: cnt = 7'($urandom_range(3, 12));
				3: cnt = 7'd0;
				4: cnt = (ph < 7) ? 7'd127 : 7'd65;
				5: cnt = 7'd1;
				default: cnt = 7'($urandom_range(2, 64));
			endcase
			configure(s, tol, cnt);
			case ((ph / 4) % 4)
				1: idle_pct = 65;
				3: idle_pct = 27;
				default: idle_pct = 0;
			endcase
			ordered   = (ph % 8 != 7);
			small_tol = (cur_tol > 1000) ? 1000 : int'(cur_tol);

			// profile over every valid entry, ascending times unless scrambled
			case ($urandom_range(3))
				0: cur = T_MIN;
				1: cur = -longint'($urandom_range(0, 4096));
				default: cur = -longint'($urandom_range(0, 32'h7fff_ffff));
			endcase
			for (int i = 0; i < eff_n; i++) begin
				if (i > 0) begin
					room = (T_MAX - cur) / (eff_n - i);
					case ($urandom_range(9))
						0: step = 0;
						1, 2: step = longint'($urandom_range(0, 2 * small_tol + 2));
						default: step = longint'($urandom_range(0, 32'(room)));
					endcase
					if (step > T_MAX - cur)
						step = T_MAX - cur;
					cur = cur + step;
					if (i == eff_n - 1 && $urandom_range(3) == 0)
						cur = T_MAX;
				end
				load_point(6'(i), ordered ? word_t'(cur) : rand_word(),
						rand_word(), rand_word(), rand_word());
			end

			// mostly queries aimed at clamps, points and interval interiors
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 12) begin
					j = $urandom_range(0, 63);
					load_point(6'(j), ($urandom_range(2) == 0) ? rand_word() : plan_time[j],
							rand_word(), rand_word(), rand_word());
				end else begin
					j  = (eff_n > 1) ? $urandom_range(0, eff_n - 2) : 0;
					lo = longint'(plan_time[j]);
					hi = longint'(plan_time[(eff_n > 1) ? j + 1 : j]);
					case ($urandom_range(9))
						0: e = longint'(plan_time[0]) - longint'($urandom_range(0, 2));
						1: e = longint'(plan_time[eff_n - 1]) + longint'($urandom_range(0, 2));
						2: e = hi;
						3: e = longint'(rand_word()) - longint'(cur_start);
						default: e = (hi > lo) ? lo + longint'($urandom_range(0, 32'(hi - lo))) : lo;
					endcase
					send_query(word_t'(e + longint'(cur_start)));
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
